[sv/mrtu_pkg.sv]
// Package for the 4x4 rotation matrix transform unit: opcodes, controller
// states, command/status structs, CORDIC constants. No dependencies.
`default_nettype none
package mrtu_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int STEP_W         = 5;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0]        DEG2RAD_Q32     = 32'd74961321;
  localparam logic signed [40:0] DEG_FULL        = 41'sd23592960;
  localparam logic signed [40:0] DEG_HALF        = 41'sd11796480;
  localparam logic signed [40:0] DEG_QUARTER     = 41'sd5898240;

  typedef enum logic [2:0] {
    OP_IDENTITY  = 3'd0,
    OP_WRITE     = 3'd1,
    OP_ROT_X     = 3'd2,
    OP_ROT_Y     = 3'd3,
    OP_ROT_Z     = 3'd4,
    OP_TRANSPOSE = 3'd5,
    OP_READ      = 3'd6,
    OP_NONE      = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_RED_A, ST_RED_B, ST_CORDIC, ST_TRIG, ST_MAC, ST_COMMIT,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_identity;
    logic do_write;
    logic do_transpose;
    logic red_a;
    logic red_b;
    logic cordic_init;
    logic cordic_step;
    logic trig;
    logic mac_start;
    logic mac_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cordic_done;
    logic mac_done;
  } sts_t;

  function automatic logic signed [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sh3243F6A8;  5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;  5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;  5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;  5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;  5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;  5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;  5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;  5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;  5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;  5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;  5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;  5'd23: v = 32'sh0000007F;
      5'd24: v = 32'sh0000003F;  5'd25: v = 32'sh0000001F;
      5'd26: v = 32'sh0000000F;  5'd27: v = 32'sh00000008;
      5'd28: v = 32'sh00000004;  5'd29: v = 32'sh00000002;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/mrtu_if.sv]
// Valid/ready channel interfaces for the command and read-out requests.
// Standalone; carries payload fields by name.
`default_nettype none
interface mrtu_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [3:0]        element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] angle_degrees;
  modport source (output valid, opcode, element_index, element_value, angle_degrees,
                  input ready);
  modport sink (input valid, opcode, element_index, element_value, angle_degrees,
                output ready);
endinterface

interface mrtu_res_if;
  logic              valid;
  logic              ready;
  logic [3:0]        out_index;
  logic signed [31:0] out_value;
  logic              out_last;
  modport source (output valid, out_index, out_value, out_last, input ready);
  modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface
`default_nettype wire

[sv/mrtu_ctrl.sv]
// Controller state machine of the transform unit. Sequences angle reduction,
// CORDIC iterations, the multiply-accumulate pass and read-out. Uses mrtu_pkg.
`default_nettype none
module mrtu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_opcode,
  input  wire mrtu_pkg::sts_t  sts,
  output mrtu_pkg::cmd_t       cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           rd_idx
);
  import mrtu_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] op_r;
  logic [3:0] rd_idx_r, rd_idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
    if (in_valid && in_ready) op_r <= in_opcode;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (opcode_t'(op_r))
          OP_ROT_X, OP_ROT_Y, OP_ROT_Z: state_nxt = ST_RED_A;
          OP_READ:                      state_nxt = ST_READ;
          default:                      state_nxt = ST_IDLE;
        endcase
      end
      ST_RED_A:  state_nxt = ST_RED_B;
      ST_RED_B:  state_nxt = ST_CORDIC;
      ST_CORDIC: if (sts.cordic_done) state_nxt = ST_TRIG;
      ST_TRIG:   state_nxt = ST_MAC;
      ST_MAC:    if (sts.mac_done) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      ST_READ:   if (out_ready && rd_idx_r == 4'd15) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: begin
        cmd.do_identity  = (op_r == OP_IDENTITY);
        cmd.do_write     = (op_r == OP_WRITE);
        cmd.do_transpose = (op_r == OP_TRANSPOSE);
        rd_idx_nxt       = '0;
      end
      ST_RED_A:  cmd.red_a = 1'b1;
      ST_RED_B:  begin
        cmd.red_b       = 1'b1;
        cmd.cordic_init = 1'b1;
      end
      ST_CORDIC: cmd.cordic_step = 1'b1;
      ST_TRIG:   begin
        cmd.trig      = 1'b1;
        cmd.mac_start = 1'b1;
      end
      ST_MAC:    cmd.mac_step = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_READ: begin
        out_valid = 1'b1;
        if (out_ready) rd_idx_nxt = rd_idx_r + 4'd1;
      end
      default: ;
    endcase
  end

  assign rd_idx = rd_idx_r;
endmodule
`default_nettype wire

[sv/mrtu_dp.sv]
// Datapath of the transform unit: matrix registers, angle reduction, shared
// CORDIC iteration unit and one shared multiplier for the matrix product.
// Uses mrtu_pkg.
`default_nettype none
module mrtu_dp #(
  parameter int ELEM_WIDTH = mrtu_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mrtu_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_accept,
  input  wire logic [2:0]         in_opcode,
  input  wire logic [3:0]         in_element_index,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic signed [31:0] in_angle_degrees,
  input  wire mrtu_pkg::cmd_t     cmd,
  output mrtu_pkg::sts_t          sts,
  input  wire logic [3:0]         rd_idx,
  output logic signed [31:0]      rd_value
);
  import mrtu_pkg::*;

  localparam int EW = ELEM_WIDTH;
  localparam int MH = EW - FRAC_BITS;         // width of m >> FRAC_BITS
  localparam int PW = FRAC_BITS + 2 + EW + 1; // product width
  localparam int AW = PW + 3;                 // accumulator width
  localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] ONE =
    (FRAC_BITS < EW - 1) ? EW'(64'sd1 <<< FRAC_BITS) : EMAX;

  function automatic logic signed [EW-1:0] sat_a(input logic signed [AW-1:0] v);
    if (v > AW'(EMAX)) return EMAX;
    if (v < AW'(EMIN)) return EMIN;
    return v[EW-1:0];
  endfunction

  logic signed [EW-1:0] m_r [16];
  logic signed [EW-1:0] n_r [16];
  logic [2:0]           w_idx_r;
  logic [3:0]           e_idx_r;
  logic signed [31:0]   e_val_r;
  logic signed [31:0]   ang_r;

  // Angle reduction and CORDIC state.
  logic signed [40:0]   a_r;
  logic                 neg_r, cneg_r;
  logic signed [33:0]   x_r, y_r;
  logic signed [33:0]   z_r;
  logic [STEP_W-1:0]    it_r;
  logic signed [EW-1:0] s_r, c_r, ns_r;

  // Matrix product: 16 outputs x 4 terms, two phases per term.
  logic [3:0]           oidx_r;
  logic [1:0]           k_r;
  logic                 ph_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic                 mac_done_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      e_idx_r <= in_element_index;
      e_val_r <= in_element_value;
      ang_r   <= in_angle_degrees;
      w_idx_r <= in_opcode - 3'd2;
    end
  end

  // A full turn is 45 * 2^19 in Q16.16, so the angle is reduced by taking the
  // upper bits modulo 45 and keeping the low 19 bits. The upper bits are offset
  // by a multiple of 45 to make them positive, and the quotient by 45 comes from
  // a reciprocal that never overshoots, followed by one correction.
  logic [13:0]        a_hp, a_qm, a_rem;
  logic [24:0]        a_qp;
  logic [8:0]         a_q;
  always_comb begin
    a_hp  = 14'($signed(ang_r[31:19])) + 14'd4140;
    a_qp  = 25'(a_hp) * 25'd1456;
    a_q   = a_qp[24:16];
    a_qm  = 14'(a_q) * 14'd45;
    a_rem = a_hp - a_qm;
    if (a_rem >= 14'd45) a_rem = a_rem - 14'd45;
  end

  // Reduction into [-180,180) then fold to [0,90].
  logic signed [40:0] a_mod, a_b, a_f;
  logic               neg_b, cneg_b;
  logic signed [72:0] z_prod;
  always_comb begin
    a_mod = {16'd0, a_rem[5:0], ang_r[18:0]};
    a_b = a_r;
    if (a_b >= DEG_HALF) a_b = a_b - DEG_FULL;
    neg_b = a_b < 0;
    if (neg_b) a_b = -a_b;
    cneg_b = a_b > DEG_QUARTER;
    a_f = cneg_b ? DEG_HALF - a_b : a_b;
    z_prod = 73'(a_f) * 73'($signed({1'b0, DEG2RAD_Q32}));
  end

  logic signed [31:0] atn;
  assign atn = atan_q30(it_r);

  logic signed [33:0] s_full, c_full;
  always_comb begin
    s_full = neg_r ? -y_r : y_r;
    c_full = cneg_r ? -x_r : x_r;
  end

  function automatic logic signed [EW-1:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v >>> (30 - FRAC_BITS);
    if (34 > EW) begin
      if (t > 34'(EMAX)) return EMAX;
      if (t < 34'(EMIN)) return EMIN;
    end
    return EW'(t);
  endfunction

  // Rotation matrix coefficient for the current output row and term.
  logic signed [EW-1:0] coef;
  logic [3:0]           rsel;
  always_comb begin
    rsel = {oidx_r[3:2], k_r};
    coef = '0;
    if (rsel == 4'd15) coef = ONE;
    case (w_idx_r)
      3'd0: case (rsel)
        4'd0: coef = ONE; 4'd5: coef = c_r; 4'd6: coef = ns_r;
        4'd9: coef = s_r; 4'd10: coef = c_r; default: ;
      endcase
      3'd1: case (rsel)
        4'd0: coef = c_r; 4'd2: coef = s_r; 4'd5: coef = ONE;
        4'd8: coef = ns_r; 4'd10: coef = c_r; default: ;
      endcase
      default: case (rsel)
        4'd0: coef = c_r; 4'd1: coef = ns_r; 4'd4: coef = s_r;
        4'd5: coef = c_r; 4'd10: coef = ONE; default: ;
      endcase
    endcase
  end

  // mulq in two multiplier passes: c*ml first, then c*mh.
  logic signed [EW-1:0]        m_sel;
  logic signed [FRAC_BITS:0]   ml;
  logic signed [MH-1:0]        mh;
  logic signed [PW-1:0]        mul_res;
  always_comb begin
    m_sel = m_r[{k_r, oidx_r[1:0]}];
    ml = {1'b0, m_sel[FRAC_BITS-1:0]};
    mh = m_sel[EW-1:FRAC_BITS];
    if (!ph_r) mul_res = PW'(coef) * PW'(ml);
    else       mul_res = PW'(coef) * PW'(mh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) m_r[i] <= '0;
      mac_done_r <= 1'b0;
    end else begin
      if (cmd.do_identity)
        for (int i = 0; i < 16; i++) m_r[i] <= (i % 5 == 0) ? ONE : '0;
      if (cmd.do_write) begin
        if (32 > EW) begin
          if (e_val_r > 32'(EMAX))      m_r[e_idx_r] <= EMAX;
          else if (e_val_r < 32'(EMIN)) m_r[e_idx_r] <= EMIN;
          else                          m_r[e_idx_r] <= EW'(e_val_r);
        end else m_r[e_idx_r] <= EW'(e_val_r);
      end
      if (cmd.do_transpose)
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++) m_r[i*4+j] <= m_r[j*4+i];
      if (cmd.commit)
        for (int i = 0; i < 16; i++) m_r[i] <= n_r[i];
      if (cmd.mac_start) mac_done_r <= 1'b0;
      else if (cmd.mac_step && ph_r && k_r == 2'd3 && oidx_r == 4'd15)
        mac_done_r <= 1'b1;
    end

    if (cmd.red_a) a_r <= a_mod;
    if (cmd.red_b) begin
      neg_r  <= neg_b;
      cneg_r <= cneg_b;
    end
    if (cmd.cordic_init) begin
      x_r  <= CORDIC_GAIN_Q30;
      y_r  <= '0;
      z_r  <= 34'(z_prod >>> 18);
      it_r <= '0;
    end else if (cmd.cordic_step && it_r != STEP_W'(CORDIC_STEPS)) begin
      if (z_r >= 0) begin
        x_r <= x_r - (y_r >>> it_r);
        y_r <= y_r + (x_r >>> it_r);
        z_r <= z_r - 34'(atn);
      end else begin
        x_r <= x_r + (y_r >>> it_r);
        y_r <= y_r - (x_r >>> it_r);
        z_r <= z_r + 34'(atn);
      end
      it_r <= it_r + STEP_W'(1);
    end
    if (cmd.trig) begin
      s_r <= sat34(s_full);
      c_r <= sat34(c_full);
      if (sat34(s_full) == EMIN) ns_r <= EMAX;
      else                       ns_r <= -sat34(s_full);
    end
    if (cmd.mac_start) begin
      oidx_r <= '0;
      k_r    <= '0;
      ph_r   <= 1'b0;
      acc_r  <= '0;
    end else if (cmd.mac_step && !mac_done_r) begin
      prod_r <= mul_res;
      ph_r   <= !ph_r;
      if (ph_r) begin
        // acc += c*mh + floor(c*ml / 2^F)
        acc_r <= acc_r + AW'(mul_res) + AW'(prod_r >>> FRAC_BITS);
        k_r   <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          n_r[oidx_r] <= sat_a(acc_r + AW'(mul_res) + AW'(prod_r >>> FRAC_BITS));
          acc_r  <= '0;
          oidx_r <= oidx_r + 4'd1;
        end
      end
    end
  end

  assign sts      = '{cordic_done: (it_r == STEP_W'(CORDIC_STEPS)), mac_done: mac_done_r};
  assign rd_value = 32'(m_r[rd_idx]);
endmodule
`default_nettype wire

[sv/matrix_rotation_transform_unit.sv]
// Top level of the 4x4 rotation matrix transform unit: ties the controller
// and datapath to the channel interfaces. Uses mrtu_pkg, mrtu_if, mrtu_ctrl, mrtu_dp.
//
//   channel | direction | payload
//   in_     | request   | opcode, element_index, element_value, angle_degrees
//   out_    | result    | out_index, out_value, out_last
//
// A request is taken in the idle cycle. Identity, write, transpose and unused opcodes
// then pass through decode and finish. A rotation runs idle, decode, angle reduction
// (modulo a full turn, then fold), the 30 CORDIC iterations, loading sine and cosine,
// the shared-multiplier passes (two for each of the 64 terms) and commit.
// A read-out takes idle, decode and 16 results, one per cycle while out_ready is high;
// out_ready low holds the current result. Reset (synchronous, rst_n low) zeroes the matrix.
`default_nettype none
module matrix_rotation_transform_unit #(
  parameter int ELEM_WIDTH = mrtu_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mrtu_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  mrtu_cmd_if.sink  in_ch,
  mrtu_res_if.source out_ch
);
  import mrtu_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [3:0] rd_idx;
  logic       in_accept;

  assign in_accept = in_ch.valid && in_ch.ready;

  mrtu_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_opcode (in_ch.opcode),
    .sts, .cmd,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .rd_idx
  );

  mrtu_dp #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_accept,
    .in_opcode (in_ch.opcode), .in_element_index (in_ch.element_index),
    .in_element_value (in_ch.element_value), .in_angle_degrees (in_ch.angle_degrees),
    .cmd, .sts, .rd_idx, .rd_value (out_ch.out_value)
  );

  assign out_ch.out_index = rd_idx;
  assign out_ch.out_last  = (rd_idx == 4'd15);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("request taken during read-out");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.out_last |=> !out_ch.valid)
    else $error("read-out ran past last element");
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_identity, cmd.do_write, cmd.do_transpose, cmd.commit}))
    else $error("conflicting matrix updates");
endmodule
`default_nettype wire
